// ----- rtl/perspective_point_projection_unit_defines.svh -----
// Assertion macros for the perspective point projection unit.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PERSPECTIVE_POINT_PROJECTION_UNIT_DEFINES_SVH
`define PERSPECTIVE_POINT_PROJECTION_UNIT_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define PPPU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pppu assertion failed");
// next-cycle implication
`define PPPU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pppu assertion failed");
`else
`define PPPU_ASSERT_NOW(lbl, ante, cons)
`define PPPU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/ppp_pkg.sv -----
// Shared widths, register indexes and pipeline payload types for the
// perspective point projection unit. No dependencies.
package ppp_pkg;

  localparam int CFG_W    = 48;
  localparam int CFG_IDX_W = 3;
  localparam int LANES    = 2;     // lane 0: horizontal, lane 1: vertical
  localparam int D_W      = 17;    // vertex minus eye
  localparam int PR_W     = 33;    // d * axis
  localparam int DOT_W    = 35;
  localparam int DEN_W    = 36;
  localparam int NUM_W    = 53;
  localparam int N_W      = 61;    // numerator scaled by 2^8
  localparam int QB       = 41;    // quotient bits resolved by the divider
  localparam int T_W      = 40;    // saturated quotient magnitude
  localparam int SCALE_W  = 24;
  localparam int HALF_W   = 20;    // multiplier split
  localparam int PP_W     = SCALE_W + HALF_W;
  localparam int P_W      = 64;
  localparam int V_W      = 34;
  localparam int FOCAL_SH = 14;
  localparam int NUM_SH   = 8;
  localparam int FRAC_SH  = 32;
  localparam int COORD_BITS_DEF = 16;
  localparam logic [15:0] FOCAL_RESET = 16'd26;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EYE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN = 3'd7;

  typedef struct packed {
    logic [N_W-1:0]   n_mag;
    logic [DEN_W-1:0] d_mag;
    logic             neg;
  } div_op_t;

  typedef struct packed {
    logic [QB-1:0] q;
    logic          rem_nz;
    logic          neg;
    logic          ovf;
  } div_res_t;

endpackage

// ----- rtl/perspective_point_projection_unit.sv -----
// Perspective point projection unit, top level: config registers, stall
// control, front / divider / back pipeline. Uses ppp_pkg and the defines header.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   in_point_x, in_point_y, in_point_z
//   out_     output     out_valid / out_stall out_screen_x, out_screen_y, out_degenerate
//   cfg_     input      cfg_we                cfg_index, cfg_data
//
// One vertex per clock unless a held result stalls the pipeline: 6 front, 42
// divider (entry plus the 41-stage one-bit-per-stage quotient pipeline), 6 back stages.
// Reset clears all valid bits and loads register defaults (focal = 26).
// A stalled output freezes the whole pipeline; in_stall is raised in that
// cycle, so no transfer is lost or repeated.
`include "perspective_point_projection_unit_defines.svh"
module perspective_point_projection_unit import ppp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [15:0]    in_point_x,
  input  logic signed [15:0]    in_point_y,
  input  logic signed [15:0]    in_point_z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    out_screen_x,
  output logic signed [15:0]    out_screen_y,
  output logic                  out_degenerate,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam logic [15:0] DEG_VAL = 16'((32'(1) << (COORD_BITS - 1)) - 32'(1));

  logic [CFG_W-1:0]   eye_r, right_r, up_r, view_r, scale_r;
  logic signed [15:0] focal_r;
  logic [31:0]        pan_r, origin_r;

  logic                 adv;
  logic                 f_vld, f_deg, d_vld, d_deg;
  div_op_t [LANES-1:0]  f_op;
  div_res_t [LANES-1:0] d_res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_r    <= '0;
      right_r  <= '0;
      up_r     <= '0;
      view_r   <= '0;
      focal_r  <= $signed(FOCAL_RESET);
      pan_r    <= '0;
      scale_r  <= '0;
      origin_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EYE:    eye_r    <= cfg_data;
        REG_RIGHT:  right_r  <= cfg_data;
        REG_UP:     up_r     <= cfg_data;
        REG_VIEW:   view_r   <= cfg_data;
        REG_FOCAL:  focal_r  <= $signed(cfg_data[15:0]);
        REG_PAN:    pan_r    <= cfg_data[31:0];
        REG_SCALE:  scale_r  <= cfg_data;
        REG_ORIGIN: origin_r <= cfg_data[31:0];
        default:    ;
      endcase
    end
  end

  // pipeline moves unless a finished result is held
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  ppp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_valid),
    .point_x  (in_point_x),
    .point_y  (in_point_y),
    .point_z  (in_point_z),
    .eye      (eye_r),
    .right_ax (right_r),
    .up_ax    (up_r),
    .view_ax  (view_r),
    .focal    (focal_r),
    .pan      (pan_r),
    .out_vld  (f_vld),
    .deg      (f_deg),
    .op       (f_op)
  );

  ppp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (f_vld),
    .in_deg  (f_deg),
    .op      (f_op),
    .out_vld (d_vld),
    .out_deg (d_deg),
    .res     (d_res)
  );

  ppp_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_vld     (d_vld),
    .in_deg     (d_deg),
    .res        (d_res),
    .scale      (scale_r),
    .origin     (origin_r),
    .out_vld    (out_valid),
    .screen_x   (out_screen_x),
    .screen_y   (out_screen_y),
    .degenerate (out_degenerate)
  );

  // input is only held back by a held result
  `PPPU_ASSERT_NOW(a_stall_source, in_stall, out_valid && out_stall)
  // degenerate results carry the saturated position on both axes
  `PPPU_ASSERT_NOW(a_deg_value, out_valid && out_degenerate, out_screen_x == DEG_VAL && out_screen_y == DEG_VAL)
  // a held result is still valid in the next cycle
  `PPPU_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid)

endmodule

// ----- rtl/ppp_front.sv -----
// Front end: eye offset, axis dot products, denominator and numerators.
// Six register stages; feeds ppp_div. Uses ppp_pkg.
module ppp_front import ppp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_vld,
  input  logic signed [15:0]     point_x,
  input  logic signed [15:0]     point_y,
  input  logic signed [15:0]     point_z,
  input  logic [CFG_W-1:0]       eye,
  input  logic [CFG_W-1:0]       right_ax,
  input  logic [CFG_W-1:0]       up_ax,
  input  logic [CFG_W-1:0]       view_ax,
  input  logic signed [15:0]     focal,
  input  logic [31:0]            pan,
  output logic                   out_vld,
  output logic                   deg,
  output div_op_t [LANES-1:0]    op
);

  localparam int FST = 6;

  logic [FST-1:0] vld_r;

  logic signed [15:0]      pt [3];
  logic [CFG_W-1:0]        ax [3];
  logic signed [D_W-1:0]   d_nxt [3], d_r [3];
  logic signed [PR_W-1:0]  pr_nxt [3][3], pr_r [3][3];
  logic signed [DOT_W-1:0] dot_nxt [LANES], dot_r [LANES];
  logic signed [DEN_W-1:0] den_nxt, den_r;
  logic signed [NUM_W-1:0] fm_nxt [LANES], fm_r [LANES];
  logic signed [NUM_W-1:0] pm_nxt [LANES], pm_r [LANES];
  logic signed [15:0]      pan_s [LANES];
  logic [DEN_W-1:0]        dmag4_nxt, dmag4_r, dmag5_r;
  logic                    dneg4_nxt, dneg4_r, dneg5_r;
  logic                    dz4_nxt, dz4_r, dz5_r;
  logic signed [NUM_W-1:0] num_nxt [LANES], num_r [LANES];
  logic signed [N_W-1:0]   nsh [LANES];
  div_op_t [LANES-1:0]     op_nxt, op_r;
  logic                    deg_r;

  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;
  assign ax[0] = right_ax;
  assign ax[1] = up_ax;
  assign ax[2] = view_ax;
  assign pan_s[0] = $signed(pan[15:0]);
  assign pan_s[1] = $signed(pan[31:16]);

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[FST-2:0], in_vld};
    end
  end

  always_comb begin
    // stage 1: vertex minus eye
    for (int k = 0; k < 3; k++) begin
      d_nxt[k] = D_W'(pt[k]) - D_W'($signed(eye[16*k +: 16]));
    end
    // stage 2: nine products
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        pr_nxt[a][k] = d_r[k] * $signed(ax[a][16*k +: 16]);
      end
    end
    // stage 3: dot sums, denominator
    for (int l = 0; l < LANES; l++) begin
      dot_nxt[l] = DOT_W'(pr_r[l][0]) + DOT_W'(pr_r[l][1]) + DOT_W'(pr_r[l][2]);
    end
    den_nxt = DEN_W'(pr_r[2][0]) + DEN_W'(pr_r[2][1]) + DEN_W'(pr_r[2][2])
            - (DEN_W'(focal) <<< FOCAL_SH);
    // stage 4: focal and pan products, denominator magnitude
    for (int l = 0; l < LANES; l++) begin
      fm_nxt[l] = focal * dot_r[l];
      pm_nxt[l] = pan_s[l] * den_r;
    end
    dz4_nxt   = (den_r == '0);
    dneg4_nxt = den_r[DEN_W-1];
    dmag4_nxt = den_r[DEN_W-1] ? DEN_W'(-den_r) : DEN_W'(den_r);
    // stage 5: numerators
    for (int l = 0; l < LANES; l++) begin
      num_nxt[l] = -fm_r[l] - pm_r[l];
    end
    // stage 6: scaled numerator magnitude and quotient sign
    for (int l = 0; l < LANES; l++) begin
      nsh[l]          = N_W'(num_r[l]) <<< NUM_SH;
      op_nxt[l].n_mag = nsh[l][N_W-1] ? N_W'(-nsh[l]) : N_W'(nsh[l]);
      op_nxt[l].d_mag = dmag5_r;
      op_nxt[l].neg   = num_r[l][NUM_W-1] ^ dneg5_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      d_r     <= d_nxt;
      pr_r    <= pr_nxt;
      dot_r   <= dot_nxt;
      den_r   <= den_nxt;
      fm_r    <= fm_nxt;
      pm_r    <= pm_nxt;
      dz4_r   <= dz4_nxt;
      dneg4_r <= dneg4_nxt;
      dmag4_r <= dmag4_nxt;
      num_r   <= num_nxt;
      dz5_r   <= dz4_r;
      dneg5_r <= dneg4_r;
      dmag5_r <= dmag4_r;
      op_r    <= op_nxt;
      deg_r   <= dz5_r;
    end
  end

  assign out_vld = vld_r[FST-1];
  assign deg     = deg_r;
  assign op      = op_r;

endmodule

// ----- rtl/ppp_div.sv -----
// Restoring divider pipeline: one quotient bit per stage, two lanes.
// Entry stage checks quotient overflow. Uses ppp_pkg.
module ppp_div import ppp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_vld,
  input  logic                  in_deg,
  input  div_op_t [LANES-1:0]   op,
  output logic                  out_vld,
  output logic                  out_deg,
  output div_res_t [LANES-1:0]  res
);

  logic [QB:0] vld_r;
  logic [QB:0] deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[QB-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      deg_r <= {deg_r[QB-1:0], in_deg};
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [DEN_W-1:0] rem_nxt [QB+1], rem_r [QB+1];
    logic [DEN_W-1:0] d_nxt   [QB+1], d_r   [QB+1];
    logic [QB-1:0]    nlo_nxt [QB+1], nlo_r [QB+1];
    logic [QB-1:0]    q_nxt   [QB+1], q_r   [QB+1];
    logic             neg_nxt [QB+1], neg_r [QB+1];
    logic             ovf_nxt [QB+1], ovf_r [QB+1];
    logic [DEN_W:0]   sh      [QB+1];
    logic [DEN_W-1:0] hi_part;

    assign hi_part = DEN_W'(op[l].n_mag[N_W-1:QB]);

    always_comb begin
      // entry: top bits seed the remainder; overflow if they reach the divisor
      rem_nxt[0] = hi_part;
      d_nxt[0]   = op[l].d_mag;
      nlo_nxt[0] = op[l].n_mag[QB-1:0];
      q_nxt[0]   = '0;
      neg_nxt[0] = op[l].neg;
      ovf_nxt[0] = (hi_part >= op[l].d_mag);
      sh[0]      = '0;
      // one trial subtraction per stage
      for (int k = 1; k <= QB; k++) begin
        sh[k]      = {rem_r[k-1], nlo_r[k-1][QB-1]};
        d_nxt[k]   = d_r[k-1];
        nlo_nxt[k] = nlo_r[k-1] << 1;
        neg_nxt[k] = neg_r[k-1];
        ovf_nxt[k] = ovf_r[k-1];
        if (sh[k] >= {1'b0, d_r[k-1]}) begin
          rem_nxt[k] = DEN_W'(sh[k] - {1'b0, d_r[k-1]});
          q_nxt[k]   = {q_r[k-1][QB-2:0], 1'b1};
        end else begin
          rem_nxt[k] = DEN_W'(sh[k]);
          q_nxt[k]   = {q_r[k-1][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r <= rem_nxt;
        d_r   <= d_nxt;
        nlo_r <= nlo_nxt;
        q_r   <= q_nxt;
        neg_r <= neg_nxt;
        ovf_r <= ovf_nxt;
      end
    end

    assign res[l].q      = q_r[QB];
    assign res[l].rem_nz = |rem_r[QB];
    assign res[l].neg    = neg_r[QB];
    assign res[l].ovf    = ovf_r[QB];
  end

  assign out_vld = vld_r[QB];
  assign out_deg = deg_r[QB];

endmodule

// ----- rtl/ppp_back.sv -----
// Back end: floor and clamp the quotient, scale, floor by 2^32, add origin,
// saturate. Six register stages, last one is the output register. Uses ppp_pkg.
module ppp_back import ppp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_vld,
  input  logic                  in_deg,
  input  div_res_t [LANES-1:0]  res,
  input  logic [CFG_W-1:0]      scale,
  input  logic [31:0]           origin,
  output logic                  out_vld,
  output logic signed [15:0]    screen_x,
  output logic signed [15:0]    screen_y,
  output logic                  degenerate
);

  localparam int BST = 6;
  localparam logic [QB:0] T_LIM = (QB+1)'(1) << (T_W - 1);
  localparam logic signed [V_W-1:0] SAT_HI = (V_W'(1) <<< (COORD_BITS - 1)) - V_W'(1);
  localparam logic signed [V_W-1:0] SAT_LO = -SAT_HI - V_W'(1);

  logic [BST-1:0] vld_r;
  logic [BST-2:0] deg_r;

  logic [QB:0]             qc [LANES];
  logic [T_W-1:0]          m_nxt [LANES], m_r [LANES];
  logic                    s_nxt [LANES], s1_r [LANES], s2_r [LANES], s3_r [LANES];
  logic                    s4_r [LANES];
  logic [SCALE_W-1:0]      sc [LANES];
  logic [PP_W-1:0]         pl_nxt [LANES], pl_r [LANES], ph_nxt [LANES], ph_r [LANES];
  logic [P_W-1:0]          p_nxt [LANES], p_r [LANES];
  logic [FRAC_SH:0]        mag_nxt [LANES], mag_r [LANES];
  logic signed [V_W-1:0]   v_nxt [LANES], v_r [LANES];
  logic signed [V_W-1:0]   sat [LANES];
  logic [15:0]             o_nxt [LANES], o_r [LANES];
  logic signed [15:0]      org [LANES];
  logic                    dg_nxt, dg_r;

  assign sc[0]  = scale[SCALE_W-1:0];
  assign sc[1]  = scale[2*SCALE_W-1:SCALE_W];
  assign org[0] = $signed(origin[15:0]);
  assign org[1] = $signed(origin[31:16]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[BST-2:0], in_vld};
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      // stage 1: floor correction toward minus infinity, clamp
      qc[l] = {1'b0, res[l].q} + (QB+1)'(res[l].neg & res[l].rem_nz);
      if (res[l].ovf || qc[l] > T_LIM) begin
        m_nxt[l] = T_W'(T_LIM);
      end else begin
        m_nxt[l] = qc[l][T_W-1:0];
      end
      // vertical axis flips sign: screen y grows downward
      s_nxt[l] = res[l].neg ^ (l == 1);
      // stage 2: split product
      pl_nxt[l] = sc[l] * m_r[l][HALF_W-1:0];
      ph_nxt[l] = sc[l] * m_r[l][T_W-1:HALF_W];
      // stage 3: recombine
      p_nxt[l] = P_W'(pl_r[l]) + (P_W'(ph_r[l]) << HALF_W);
      // stage 4: magnitude of the floored quotient by 2^32
      mag_nxt[l] = (FRAC_SH+1)'(p_r[l][P_W-1:FRAC_SH]) + (FRAC_SH+1)'(s3_r[l] && (|p_r[l][FRAC_SH-1:0]));
      // stage 5: apply sign, add origin
      v_nxt[l] = (s4_r[l] ? -V_W'(mag_r[l]) : V_W'(mag_r[l])) + V_W'(org[l]);
      // stage 6: saturate
      if (v_r[l] > SAT_HI) begin
        sat[l] = SAT_HI;
      end else if (v_r[l] < SAT_LO) begin
        sat[l] = SAT_LO;
      end else begin
        sat[l] = v_r[l];
      end
      o_nxt[l] = deg_r[BST-2] ? SAT_HI[15:0] : sat[l][15:0];
    end
    dg_nxt = deg_r[BST-2];
  end

  // note: floor of a positive product is the plain upper half; a negative
  // result rounds its magnitude up when any fraction bit is set
  always_ff @(posedge clk) begin
    if (adv) begin
      deg_r <= {deg_r[BST-3:0], in_deg};
      m_r   <= m_nxt;
      s1_r  <= s_nxt;
      pl_r  <= pl_nxt;
      ph_r  <= ph_nxt;
      s2_r  <= s1_r;
      p_r   <= p_nxt;
      s3_r  <= s2_r;
      mag_r <= mag_nxt;
      s4_r  <= s3_r;
      v_r   <= v_nxt;
      o_r   <= o_nxt;
      dg_r  <= dg_nxt;
    end
  end

  assign out_vld    = vld_r[BST-1];
  assign screen_x   = $signed(o_r[0]);
  assign screen_y   = $signed(o_r[1]);
  assign degenerate = dg_r;

endmodule

// ----- verif/tb.sv -----
// Testbench for perspective_point_projection_unit: directed and random vertex
// streams against an in-bench projection predictor. Depends on ppp_pkg and the RTL.
module tb;
  import ppp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT = 54;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               degen;
  } pixel_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, out_degenerate, cfg_we;
  logic signed [15:0] in_point_x, in_point_y, in_point_z, out_screen_x, out_screen_y;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  perspective_point_projection_unit uut (.*);

  // camera registers mirrored by the predictor
  logic [47:0] eye_r, right_r, up_r, view_r, scale_r;
  logic [15:0] focal_r;
  logic [31:0] pan_r, origin_r;

  pixel_t pixel_q[$];
  bit failed = 0;
  int idle_cycles = 0;
  int stall_mode = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Floor division on wide signed values
  function automatic logic signed [127:0] fdiv(logic signed [127:0] a,
      logic signed [127:0] b);
    logic signed [127:0] q, r;
    q = a / b;
    r = a % b;
    if (r != 0 && ((r < 0) != (b < 0))) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [127:0] axis_dot(logic signed [127:0] d0,
      logic signed [127:0] d1, logic signed [127:0] d2, logic [47:0] ax);
    return d0 * $signed(ax[15:0]) + d1 * $signed(ax[31:16]) + d2 * $signed(ax[47:32]);
  endfunction

  function automatic logic signed [15:0] clamp_pix(logic signed [127:0] v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic logic signed [127:0] lane_pixel(logic signed [127:0] adot,
      logic signed [127:0] den, logic signed [127:0] focal, logic signed [15:0] pan,
      logic [23:0] scl, logic signed [15:0] org, bit flip);
    logic signed [127:0] num, t, prod, lim;
    lim = 128'sd1 <<< 39;
    num = -focal * adot - pan * den;
    t = fdiv(num * 256, den);
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    prod = $signed({104'd0, scl}) * t;
    if (flip) prod = -prod;
    return fdiv(prod, 128'sd1 <<< 32) + org;
  endfunction

  function automatic pixel_t project_vertex(logic signed [15:0] px, logic signed [15:0] py,
      logic signed [15:0] pz);
    pixel_t r;
    logic signed [127:0] d0, d1, d2, focal, den;
    d0 = px - $signed(eye_r[15:0]);
    d1 = py - $signed(eye_r[31:16]);
    d2 = pz - $signed(eye_r[47:32]);
    focal = $signed(focal_r);
    den = axis_dot(d0, d1, d2, view_r) - focal * 16384;
    if (den == 0) begin
      r.sx = 16'sd32767; r.sy = 16'sd32767; r.degen = 1'b1;
      return r;
    end
    r.sx = clamp_pix(lane_pixel(axis_dot(d0, d1, d2, right_r), den, focal,
                                $signed(pan_r[15:0]), scale_r[23:0],
                                $signed(origin_r[15:0]), 0));
    r.sy = clamp_pix(lane_pixel(axis_dot(d0, d1, d2, up_r), den, focal,
                                $signed(pan_r[31:16]), scale_r[47:24],
                                $signed(origin_r[31:16]), 1));
    r.degen = 1'b0;
    return r;
  endfunction

  // Register write; only called while the pipeline is empty
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_EYE:    eye_r = val;
      REG_RIGHT:  right_r = val;
      REG_UP:     up_r = val;
      REG_VIEW:   view_r = val;
      REG_FOCAL:  focal_r = val[15:0];
      REG_PAN:    pan_r = val[31:0];
      REG_SCALE:  scale_r = val;
      REG_ORIGIN: origin_r = val[31:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // One vertex transfer; holds valid until accepted
  task automatic send_vertex(logic signed [15:0] px, logic signed [15:0] py,
      logic signed [15:0] pz);
    in_valid <= 1'b1; in_point_x <= px; in_point_y <= py; in_point_z <= pz;
    do @(posedge clk); while (in_stall);
    pixel_q.push_back(project_vertex(px, py, pz));
  endtask

  task automatic send_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 4)) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  // Result check against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d deg=%0d", $time, out_screen_x,
                 out_screen_y, out_degenerate);
        failed = 1;
      end else begin
        pixel_t e;
        e = pixel_q.pop_front();
        if (e.sx !== out_screen_x) begin
          $display("%0t: screen_x expected %0d actual %0d", $time, e.sx, out_screen_x);
          failed = 1;
        end
        if (e.sy !== out_screen_y) begin
          $display("%0t: screen_y expected %0d actual %0d", $time, e.sy, out_screen_y);
          failed = 1;
        end
        if (e.degen !== out_degenerate) begin
          $display("%0t: degenerate expected %0d actual %0d", $time, e.degen, out_degenerate);
          failed = 1;
        end
      end
    end
  end

  // Receiver stall pattern; mode 0 never stalls
  always @(posedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("perspective_point_projection_unit verification failed");
      $finish;
    end
  end

  function automatic logic [47:0] rand_axes();
    return {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
            16'($urandom_range(0, 65535))};
  endfunction

  // Typical camera unless wild: axis values around unit, eye behind origin; wild draws random axes and eye
  task automatic set_camera(bit wild);
    write_reg(REG_EYE, wild ? rand_axes() : {16'sd2560, 16'sd0, 16'sd0});
    write_reg(REG_RIGHT, wild ? rand_axes() : {16'sd0, 16'sd0, 16'sd16384});
    write_reg(REG_UP, wild ? rand_axes() : {16'sd0, 16'sd16384, 16'sd0});
    write_reg(REG_VIEW, wild ? rand_axes() : {16'sd16384, 16'sd0, 16'sd0});
    write_reg(REG_FOCAL, 48'($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                       : $urandom_range(256, 2560)));
    write_reg(REG_PAN, 48'({16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))}));
    write_reg(REG_SCALE, {24'($urandom_range(0, 24'hffffff)),
                          24'($urandom_range(0, 24'hffffff))});
    write_reg(REG_ORIGIN, 48'({16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535))}));
  endtask

  // Reset defaults: zero axes and zero pan give a zero numerator so pixels equal origin
  task automatic test_reset_defaults();
    send_vertex(16'sd0, 16'sd0, 16'sd0);
    send_vertex(16'sh7fff, -16'sh8000, 16'sd100);
    drain();
  endtask

  // Field extremes, degenerate denominator, zero scale, full scale with focal, origin and pan extremes
  task automatic test_directed();
    logic signed [15:0] ext[4];
    ext = '{16'sh7fff, -16'sh8000, 16'sd0, -16'sd1};
    set_camera(0);
    foreach (ext[i]) send_vertex(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4]);
    drain();
    // vertex on the projection plane: view dot equals focal
    write_reg(REG_FOCAL, 48'h100);
    write_reg(REG_EYE, 48'd0);
    send_vertex(16'sd0, 16'sd0, 16'sd256);
    send_vertex(16'sd5, 16'sd3, 16'sd256);
    drain();
    write_reg(REG_ORIGIN, 48'd0);
    write_reg(REG_SCALE, 48'd0);
    send_vertex(16'sd100, -16'sd200, 16'sd300);
    drain();
    write_reg(REG_SCALE, 48'hffffff_ffffff);
    write_reg(REG_FOCAL, 48'h8000);
    send_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff);
    drain();
    write_reg(REG_FOCAL, 48'h7fff);
    send_vertex(-16'sh8000, -16'sh8000, -16'sh8000);
    drain();
    write_reg(REG_ORIGIN, 48'h8000_7fff);
    write_reg(REG_PAN, 48'h8000_7fff);
    send_vertex(16'sd1, 16'sd1, 16'sd1);
    drain();
  endtask

  // Random vertices in bursts; camera changes between phases
  task automatic test_random_stream(int phases, int per_phase, bit wild);
    for (int ph = 0; ph < phases; ph++) begin
      stall_mode = ph % 3;
      set_camera(wild && (ph % 2 == 1));
      for (int n = 0; n < per_phase; ) begin
        int burst;
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst && n < per_phase; b++, n++) begin
          if ($urandom_range(0, 3) == 0)
            send_vertex(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)));
          else
            send_vertex(16'($urandom_range(0, 4096) - 2048),
                        16'($urandom_range(0, 4096) - 2048),
                        16'($urandom_range(0, 4096) - 2048));
        end
        if ($urandom_range(0, 2) != 0) send_gap();
      end
      drain();
    end
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_point_x = 0; in_point_y = 0; in_point_z = 0;
    out_stall = 0; cfg_we = 0; cfg_index = REG_EYE; cfg_data = '0;
    eye_r = '0; right_r = '0; up_r = '0; view_r = '0; scale_r = '0;
    focal_r = FOCAL_RESET; pan_r = '0; origin_r = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random_stream(6, 150, 0);
    test_random_stream(6, 150, 1);
    if (!failed) begin
      $display("perspective_point_projection_unit verification clean");
    end else begin
      $display("perspective_point_projection_unit verification failed");
    end
    $finish;
  end
endmodule
